>>> rtl/pfsw_pkg.sv
package pfsw_pkg;

    localparam int FRAME_W = 64;
    localparam int WORD_W  = 32;
    localparam int GAIN_W  = 10;
    localparam int CFG_W   = 6;
    localparam int CHAN_W  = 2;

    // Register indexes on the configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTAINER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNIFICANT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 2'd3;
    localparam int CFG_DATA_W = GAIN_W;

    localparam logic [CFG_W-1:0]  WIDTH_SHORT  = 6'd16;
    localparam logic [CFG_W-1:0]  WIDTH_MEDIUM = 6'd24;
    localparam logic [CFG_W-1:0]  WIDTH_FULL   = 6'd32;
    localparam logic [CHAN_W-1:0] CHAN_STEREO  = 2'd2;
    localparam logic [GAIN_W-1:0] GAIN_UNITY   = 10'd100;

    // Pipeline stages, valid bits travel alongside in the control block
    localparam int PIPE_DEPTH = 7;
    localparam int ST_UNPACK  = 0;
    localparam int ST_DIV     = 1;
    localparam int ST_ALIGN   = 2;
    localparam int ST_GAIN    = 3;
    localparam int ST_PART    = 4;
    localparam int ST_SUM     = 5;
    localparam int ST_SAT     = 6;

    // Division by 100 through a reciprocal: product below 2^41 is exact at shift 48
    localparam int PROD_W      = WORD_W + GAIN_W;
    localparam int GAIN_DIV    = 100;
    localparam int RECIP_SHIFT = 48;
    localparam int RECIP_W     = 42;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(GAIN_DIV) - 64'd1) / 64'(GAIN_DIV);
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_FULL[RECIP_W-1:0];
    localparam int SPLIT_W   = 32;
    localparam int HI_W      = PROD_W - SPLIT_W;
    localparam int RHI_W     = RECIP_W - SPLIT_W;
    localparam int SUM_W     = PROD_W + RECIP_W;
    localparam int QUOT_W    = SUM_W - 1 - RECIP_SHIFT;

    localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        CW_16,
        CW_24,
        CW_32
    } t_cw;

    typedef struct packed {
        t_cw               cw;
        logic              stereo;
        logic [CFG_W-1:0]  div_sh;
        logic [CFG_W-1:0]  align_sh;
        logic [GAIN_W-1:0] gain;
    } t_fmt;

    typedef struct packed {
        logic [PIPE_DEPTH-1:0] en;
    } t_pipe_ctl;

endpackage

>>> rtl/pcm_frame_to_stereo_word_volume_top.sv
// Channel   Handshake                  Payload
// in        i_in_valid / o_in_ready    i_frame_data[63:0], i_frame_last
// out       o_out_valid / i_out_ready  o_left_word, o_right_word, o_end_of_chunk
// cfg       i_cfg_we (no wait)         i_cfg_index[1:0], i_cfg_data[9:0]
//
// One word enters per cycle while o_in_ready is high; each passes in order
// through the seven register stages: the unpack stage and the six stages of
// each lane.
// Reset clears the stage valid bits and loads the register defaults.
// A stall at the output holds the stages behind it only as far as they are
// full: empty stages keep filling, so bubbles close up and nothing is lost.
module pcm_frame_to_stereo_word_volume_top
    import pfsw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [FRAME_W-1:0]    i_frame_data,
    input  logic                  i_frame_last,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [WORD_W-1:0] o_left_word,
    output logic signed [WORD_W-1:0] o_right_word,
    output logic                  o_end_of_chunk,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CFG_W-1:0]  r_container;
    logic [CFG_W-1:0]  r_significant;
    logic [CHAN_W-1:0] r_channels;
    logic [GAIN_W-1:0] r_gain;

    // Register writes land straight away; there is no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_container   <= WIDTH_SHORT;
            r_significant <= WIDTH_SHORT;
            r_channels    <= CHAN_STEREO;
            r_gain        <= GAIN_UNITY;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CONTAINER:   r_container   <= i_cfg_data[CFG_W-1:0];
                CFG_SIGNIFICANT: r_significant <= i_cfg_data[CFG_W-1:0];
                CFG_CHANNELS:    r_channels    <= i_cfg_data[CHAN_W-1:0];
                CFG_GAIN:        r_gain        <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Decode the format once; the user must change it only while the pipe is empty, the block does not enforce this
    t_fmt             fmt;
    logic [CFG_W-1:0] cw_bits;

    always_comb begin
        if (r_container == WIDTH_SHORT) begin
            fmt.cw  = CW_16;
            cw_bits = WIDTH_SHORT;
        end else if (r_container == WIDTH_MEDIUM) begin
            fmt.cw  = CW_24;
            cw_bits = WIDTH_MEDIUM;
        end else begin
            fmt.cw  = CW_32;
            cw_bits = WIDTH_FULL;
        end
        fmt.stereo = (r_channels == CHAN_STEREO);
        // Scale down only when fewer bits are significant than the container holds
        fmt.div_sh = (r_significant < cw_bits) ? (cw_bits - r_significant) : '0;
        // Significant widths above the full word need no alignment
        fmt.align_sh = (r_significant > WIDTH_FULL) ? '0 : (WIDTH_FULL - r_significant);
        fmt.gain     = r_gain;
    end

    t_pipe_ctl                ctl;
    logic signed [WORD_W-1:0] left_sample;
    logic signed [WORD_W-1:0] right_sample;
    logic [WORD_W-1:0]        left_word;
    logic [WORD_W-1:0]        right_word;

    pfsw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_frame_last),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_out_last  (o_end_of_chunk),
        .i_out_ready (i_out_ready),
        .o_ctl       (ctl)
    );

    // Pick the two samples out of the frame; mono copies left to right
    pfsw_unpack u_unpack (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_fmt   (fmt),
        .i_frame (i_frame_data),
        .o_left  (left_sample),
        .o_right (right_sample)
    );

    // Identical lanes: scale, align, apply gain, divide by 100, clamp
    pfsw_lane u_lane_left (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_fmt    (fmt),
        .i_sample (left_sample),
        .o_word   (left_word)
    );

    pfsw_lane u_lane_right (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_fmt    (fmt),
        .i_sample (right_sample),
        .o_word   (right_word)
    );

    assign o_left_word  = $signed(left_word);
    assign o_right_word = $signed(right_word);

endmodule

>>> rtl/pfsw_ctrl.sv
module pfsw_ctrl
    import pfsw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_last,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output logic      o_out_last,
    input  logic      i_out_ready,
    output t_pipe_ctl o_ctl
);

    logic [PIPE_DEPTH-1:0] r_valid;
    logic [PIPE_DEPTH-1:0] r_last;
    logic [PIPE_DEPTH-1:0] rdy;

    // A stage loads when it is empty or its contents move on
    always_comb begin
        rdy[PIPE_DEPTH-1] = !r_valid[PIPE_DEPTH-1] || i_out_ready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            rdy[k] = !r_valid[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (rdy[0]) begin
                r_valid[0] <= i_in_valid;
            end
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                if (rdy[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_last[0] <= i_in_last;
        end
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            if (rdy[k]) begin
                r_last[k] <= r_last[k-1];
            end
        end
    end

    assign o_ctl.en    = rdy;
    assign o_in_ready  = rdy[0];
    assign o_out_valid = r_valid[PIPE_DEPTH-1];
    assign o_out_last  = r_last[PIPE_DEPTH-1];

endmodule

>>> rtl/pfsw_unpack.sv
module pfsw_unpack
    import pfsw_pkg::*;
(
    input  logic                     i_clk,
    input  t_pipe_ctl                i_ctl,
    input  t_fmt                     i_fmt,
    input  logic [FRAME_W-1:0]       i_frame,
    output logic signed [WORD_W-1:0] o_left,
    output logic signed [WORD_W-1:0] o_right
);

    logic signed [WORD_W-1:0] r_left;
    logic signed [WORD_W-1:0] r_right;
    logic signed [WORD_W-1:0] n_left;
    logic signed [WORD_W-1:0] n_right;
    logic signed [WORD_W-1:0] second;

    // Second sample starts right after the first container
    always_comb begin
        case (i_fmt.cw)
            CW_16: begin
                n_left = {{16{i_frame[15]}}, i_frame[15:0]};
                second = {{16{i_frame[31]}}, i_frame[31:16]};
            end
            CW_24: begin
                n_left = {{8{i_frame[23]}}, i_frame[23:0]};
                second = {{8{i_frame[47]}}, i_frame[47:24]};
            end
            default: begin
                n_left = i_frame[31:0];
                second = i_frame[63:32];
            end
        endcase
        n_right = i_fmt.stereo ? second : n_left;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_UNPACK]) begin
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    assign o_left  = r_left;
    assign o_right = r_right;

endmodule

>>> rtl/pfsw_lane.sv
module pfsw_lane
    import pfsw_pkg::*;
(
    input  logic                     i_clk,
    input  t_pipe_ctl                i_ctl,
    input  t_fmt                     i_fmt,
    input  logic signed [WORD_W-1:0] i_sample,
    output logic [WORD_W-1:0]        o_word
);

    // Divide by a power of two, rounding toward zero
    logic [WORD_W:0]            div_mask;
    logic signed [WORD_W+1:0]   div_biased;
    logic signed [WORD_W+1:0]   div_shifted;
    logic [WORD_W-1:0]          r_div;

    always_comb begin
        div_mask    = (33'd1 << i_fmt.div_sh) - 33'd1;
        div_biased  = {{2{i_sample[WORD_W-1]}}, i_sample}
                    + (i_sample[WORD_W-1] ? $signed({1'b0, div_mask}) : 34'sd0);
        div_shifted = div_biased >>> i_fmt.div_sh;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_DIV]) begin
            r_div <= div_shifted[WORD_W-1:0];
        end
    end

    // Left-align and split into sign and magnitude
    logic [WORD_W-1:0] aligned;
    logic [WORD_W-1:0] r_mag;
    logic              r_sign_al;

    assign aligned = r_div << i_fmt.align_sh;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_ALIGN]) begin
            r_sign_al <= aligned[WORD_W-1];
            r_mag     <= aligned[WORD_W-1] ? (~aligned + 32'd1) : aligned;
        end
    end

    // Apply gain
    logic [PROD_W-1:0] r_prod;
    logic              r_sign_gn;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_GAIN]) begin
            r_sign_gn <= r_sign_al;
            r_prod    <= PROD_W'(r_mag) * PROD_W'(i_fmt.gain);
        end
    end

    // Reciprocal product in four parts
    logic [2*SPLIT_W-1:0]     r_pp_ll;
    logic [SPLIT_W+RHI_W-1:0] r_pp_lh;
    logic [HI_W+SPLIT_W-1:0]  r_pp_hl;
    logic [HI_W+RHI_W-1:0]    r_pp_hh;
    logic                     r_sign_pp;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_PART]) begin
            r_sign_pp <= r_sign_gn;
            r_pp_ll   <= (2*SPLIT_W)'(r_prod[SPLIT_W-1:0])
                       * (2*SPLIT_W)'(RECIP_100[SPLIT_W-1:0]);
            r_pp_lh   <= (SPLIT_W+RHI_W)'(r_prod[SPLIT_W-1:0])
                       * (SPLIT_W+RHI_W)'(RECIP_100[RECIP_W-1:SPLIT_W]);
            r_pp_hl   <= (HI_W+SPLIT_W)'(r_prod[PROD_W-1:SPLIT_W])
                       * (HI_W+SPLIT_W)'(RECIP_100[SPLIT_W-1:0]);
            r_pp_hh   <= (HI_W+RHI_W)'(r_prod[PROD_W-1:SPLIT_W])
                       * (HI_W+RHI_W)'(RECIP_100[RECIP_W-1:SPLIT_W]);
        end
    end

    // Gather the parts, keep the quotient
    logic [SUM_W-1:0]  pp_sum;
    logic [QUOT_W-1:0] r_quot;
    logic              r_sign_q;

    assign pp_sum = SUM_W'(r_pp_ll)
                  + (SUM_W'(r_pp_lh) << SPLIT_W)
                  + (SUM_W'(r_pp_hl) << SPLIT_W)
                  + (SUM_W'(r_pp_hh) << (2*SPLIT_W));

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_SUM]) begin
            r_sign_q <= r_sign_pp;
            r_quot   <= pp_sum[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
        end
    end

    // Restore sign, clamp to the word range
    logic [WORD_W-1:0] n_word;
    logic [WORD_W-1:0] r_word;

    always_comb begin
        if (!r_sign_q) begin
            n_word = (r_quot > QUOT_W'(WORD_MAX)) ? WORD_MAX : r_quot[WORD_W-1:0];
        end else begin
            n_word = (r_quot > QUOT_W'(WORD_MIN)) ? WORD_MIN
                   : (~r_quot[WORD_W-1:0] + 32'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_SAT]) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule
